// ===== rtl/ngram_bitmap_query_prefilter_core_defines.svh =====
// Assertion macros shared by the RTL of the n-gram query prefilter.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef NGRAM_BITMAP_QUERY_PREFILTER_CORE_DEFINES_SVH
`define NGRAM_BITMAP_QUERY_PREFILTER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define NBQP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nbqp assertion failed");
`define NBQP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nbqp assertion failed");
`else
`define NBQP_ASSERT_IMP(label, ante, cons)
`define NBQP_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/nbqp_pkg.sv =====
package nbqp_pkg;

  localparam int WORD_W     = 64;
  localparam int MAP_AW     = 10;
  localparam int MAP_DEPTH  = 1024;
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;

  localparam logic       REQ_LOAD    = 1'b0;
  localparam logic       REQ_QUERY   = 1'b1;
  localparam logic [1:0] SEL_BYTE    = 2'd0;
  localparam logic [1:0] SEL_BIGRAM  = 2'd1;
  localparam logic [1:0] SEL_TRIGRAM = 2'd2;

  localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;

  typedef struct packed {
    logic load_we;
    logic q_start;
    logic bg_chk;
    logic mul2;
    logic tri_rd_lo;
    logic tri_rd_hi;
    logic tri_chk;
    logic finish;
  } nbqp_cmd_t;

  typedef struct packed {
    logic seen_ge2;
    logic out_stall;
  } nbqp_sts_t;

endpackage

// ===== rtl/nbqp_ram.sv =====
module nbqp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nbqp_datapath.sv =====
`include "ngram_bitmap_query_prefilter_core_defines.svh"

module nbqp_datapath
  import nbqp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  nbqp_cmd_t             cmd,
  output nbqp_sts_t             sts,
  input  logic [1:0]            table_select,
  input  logic [MAP_AW-1:0]     word_index,
  input  logic [WORD_W-1:0]     word_data,
  input  logic [7:0]            query_byte,
  input  logic                  query_last,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [WORD_W-1:0] byte_map_r [4];
  logic [7:0]        older_r;
  logic [7:0]        newer_r;
  logic [1:0]        seen_r;
  logic              all_found_r;
  logic [7:0]        cur_r;
  logic              last_r;
  logic [31:0]       v1_r;
  logic [31:0]       m1_r;
  logic [31:0]       m2_r;
  logic              out_valid_r;
  logic              out_bit_r;

  logic [31:0]       window;
  logic [31:0]       v2;
  logic [31:0]       hash;
  logic [WORD_W-1:0] bg_rdata;
  logic [WORD_W-1:0] tri_rdata;
  logic [MAP_AW-1:0] tri_raddr;
  logic              hit;

  assign window    = {8'd0, older_r, newer_r, query_byte};
  assign v2        = m1_r ^ (m1_r >> 15);
  assign hash      = m2_r ^ (m2_r >> 16);
  assign tri_raddr = cmd.tri_rd_hi ? hash[31:22] : hash[15:6];
  assign hit       = (seen_r == 2'd0) ? byte_map_r[cur_r[7:6]][cur_r[5:0]] : all_found_r;

  nbqp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_DEPTH)
  ) u_bigram_ram (
    .clk  (clk),
    .we   (cmd.load_we && (table_select == SEL_BIGRAM)),
    .waddr(word_index),
    .wdata(word_data),
    .re   (cmd.q_start),
    .raddr({newer_r, query_byte[7:6]}),
    .rdata(bg_rdata)
  );

  nbqp_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_DEPTH)
  ) u_trigram_ram (
    .clk  (clk),
    .we   (cmd.load_we && (table_select == SEL_TRIGRAM)),
    .waddr(word_index),
    .wdata(word_data),
    .re   (cmd.tri_rd_lo || cmd.tri_rd_hi),
    .raddr(tri_raddr),
    .rdata(tri_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_we && (table_select == SEL_BYTE) && (word_index[MAP_AW-1:2] == '0)) begin
      byte_map_r[word_index[1:0]] <= word_data;
    end
    if (cmd.q_start) begin
      cur_r  <= query_byte;
      last_r <= query_last;
      v1_r   <= window ^ (window >> 16);
    end
    if (cmd.bg_chk) begin
      m1_r <= 32'(v1_r * HASH_MUL_A);
    end
    if (cmd.mul2) begin
      m2_r <= 32'(v2 * HASH_MUL_B);
    end
    if (cmd.finish && last_r) begin
      out_bit_r <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= '0;
      newer_r     <= '0;
      seen_r      <= '0;
      all_found_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.bg_chk && (seen_r != 2'd0) && !bg_rdata[cur_r[5:0]]) begin
        all_found_r <= 1'b0;
      end
      if (cmd.tri_rd_hi && !tri_rdata[hash[5:0]]) begin
        all_found_r <= 1'b0;
      end
      if (cmd.tri_chk && !tri_rdata[hash[21:16]]) begin
        all_found_r <= 1'b0;
      end
      if (cmd.finish) begin
        if (last_r) begin
          older_r     <= '0;
          newer_r     <= '0;
          seen_r      <= '0;
          all_found_r <= 1'b1;
        end else begin
          older_r <= newer_r;
          newer_r <= cur_r;
          if (seen_r != 2'd2) begin
            seen_r <= seen_r + 2'd1;
          end
        end
      end
    end
  end

  assign sts.seen_ge2  = (seen_r == 2'd2);
  assign sts.out_stall = last_r && out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_bit_r};

  `NBQP_ASSERT_NXT(a_last_clears_query, cmd.finish && last_r,
                   out_valid_r && (seen_r == 2'd0) && all_found_r)
  `NBQP_ASSERT_NXT(a_load_keeps_query, cmd.load_we,
                   $stable(seen_r) && $stable(newer_r) && $stable(all_found_r))
  `NBQP_ASSERT_IMP(a_trigram_needs_two, cmd.tri_rd_lo || cmd.tri_rd_hi || cmd.tri_chk,
                   seen_r == 2'd2)

endmodule

// ===== rtl/nbqp_ctrl.sv =====
`include "ngram_bitmap_query_prefilter_core_defines.svh"

module nbqp_ctrl
  import nbqp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_req_type,
  output logic      in_tready,
  output nbqp_cmd_t cmd,
  input  nbqp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BG,
    S_MUL2,
    S_TLO,
    S_THI,
    S_TCHK,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && (in_req_type == REQ_QUERY)) begin
          state_nxt = S_BG;
        end
      end
      S_BG:   state_nxt = sts.seen_ge2 ? S_MUL2 : S_DONE;
      S_MUL2: state_nxt = S_TLO;
      S_TLO:  state_nxt = S_THI;
      S_THI:  state_nxt = S_TCHK;
      S_TCHK: state_nxt = S_DONE;
      S_DONE: begin
        if (!sts.out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready     = (state_r == S_IDLE);
  assign cmd.load_we   = in_tready && in_tvalid && (in_req_type == REQ_LOAD);
  assign cmd.q_start   = in_tready && in_tvalid && (in_req_type == REQ_QUERY);
  assign cmd.bg_chk    = (state_r == S_BG);
  assign cmd.mul2      = (state_r == S_MUL2);
  assign cmd.tri_rd_lo = (state_r == S_TLO);
  assign cmd.tri_rd_hi = (state_r == S_THI);
  assign cmd.tri_chk   = (state_r == S_TCHK);
  assign cmd.finish    = (state_r == S_DONE) && !sts.out_stall;

  `NBQP_ASSERT_NXT(a_query_enters_bg, cmd.q_start, state_r == S_BG)
  `NBQP_ASSERT_IMP(a_tchk_after_thi, state_r == S_TCHK, $past(state_r) == S_THI)
  `NBQP_ASSERT_NXT(a_stall_holds_done, (state_r == S_DONE) && sts.out_stall,
                   state_r == S_DONE)

endmodule

// ===== rtl/ngram_bitmap_query_prefilter_core.sv =====
// Channel | Direction | Signals
// in      | input     | in_tvalid, in_tready, in_tdata, in_tuser, in_tlast
// out     | output    | out_tvalid, out_tready, out_tdata
//
// A load beat writes its word in the cycle it is accepted. A query byte goes
// through the bigram check state and then the done state; from the third byte
// of the query on, the second chained hash multiply, the two reads through the
// trigram memory's single read port and the trigram check lie between, and no
// new beat is taken before the byte is done. The final byte of a query waits
// while the previous result is still held in the output register and not taken.
// Reset is synchronous and clears the query state and the output register; the bitmaps are not cleared.
module ngram_bitmap_query_prefilter_core
  import nbqp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // word_index [9:0], word_data [73:10], query_byte [81:74], zero fill above.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type [0], table_select [2:1].
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // maybe_present [0], zero fill above.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  nbqp_cmd_t cmd;
  nbqp_sts_t sts;

  nbqp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_req_type(in_tuser[0]),
    .in_tready  (in_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  nbqp_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .table_select(in_tuser[2:1]),
    .word_index  (in_tdata[9:0]),
    .word_data   (in_tdata[73:10]),
    .query_byte  (in_tdata[81:74]),
    .query_last  (in_tlast),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nbqp_pkg::*;

  localparam logic [1:0]  SEL_UNUSED = 2'd3;
  localparam logic [63:0] ONES       = '1;
  localparam logic [63:0] ZERO       = '0;
  localparam int          HOLD_CYCLES = 400;
  localparam int          RANDOM_ITEMS = 910;

  typedef struct packed {
    logic        req;
    logic [1:0]  sel;
    logic [9:0]  idx;
    logic [63:0] data;
    logic [7:0]  qb;
    logic        last;
    logic        typed;
    logic        typed_hit;
  } dir_row_t;

  localparam int N_DIR = 28;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{REQ_LOAD,  SEL_BYTE,    10'd0,    ONES, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,  SEL_BYTE,    10'd3,    ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h00, 1'b1, 1'b1, 1'b1},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'hff, 1'b1, 1'b1, 1'b0},
    '{REQ_LOAD,  SEL_BYTE,    10'd4,    ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,  SEL_BYTE,    10'd1023, ONES, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h00, 1'b1, 1'b1, 1'b1},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'hff, 1'b1, 1'b1, 1'b0},
    '{REQ_LOAD,  SEL_UNUSED,  10'd0,    ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h00, 1'b1, 1'b1, 1'b1},
    '{REQ_LOAD,  SEL_BIGRAM,  10'd0,    ONES, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,  SEL_BIGRAM,  10'd1023, ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h00, 1'b1, 1'b1, 1'b1},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'hff, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'hff, 1'b1, 1'b1, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h12, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,  SEL_BIGRAM,  10'h048,  ONES, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h34, 1'b1, 1'b1, 1'b1},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h12, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,  SEL_BIGRAM,  10'h048,  ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h34, 1'b1, 1'b1, 1'b0},
    '{REQ_LOAD,  SEL_TRIGRAM, 10'd0,    ONES, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,  SEL_TRIGRAM, 10'd1023, ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'hff, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h00, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'ha5, 1'b0, 1'b0, 1'b0},
    '{REQ_QUERY, SEL_BYTE,    10'd0,    ZERO, 8'h5a, 1'b1, 1'b0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Shadow copy of the bitmaps and of the query window.
  logic [63:0] byte_words    [4];
  logic [63:0] bigram_words  [MAP_DEPTH];
  logic [63:0] trigram_words [MAP_DEPTH];
  bit          bigram_set    [MAP_DEPTH];
  bit          trigram_set   [MAP_DEPTH];
  logic [7:0]  win_older = '0;
  logic [7:0]  win_newer = '0;
  int          win_count = 0;
  bit          all_hit   = 1'b1;

  bit presence_q [$];
  bit want;
  int snd_idle  = 0;
  int rcv_idle  = 0;
  int hold_ask  = 0;
  int hold_done = 0;
  int hold_left = 0;
  int errors    = 0;
  int n_loads   = 0;
  int n_bytes   = 0;
  int n_results = 0;
  int n_present = 0;

  ngram_bitmap_query_prefilter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] avalanche(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * HASH_MUL_A;
    v = v ^ (v >> 15);
    v = v * HASH_MUL_B;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] dense_word();
    return rand_word() | rand_word() | rand_word();
  endfunction

  task automatic track_beat(input logic req, input logic [1:0] sel, input logic [9:0] idx,
                            input logic [63:0] data, input logic [7:0] qb, input logic last,
                            output bit has_res, output bit res);
    logic [15:0] pair;
    logic [31:0] h;
    bit          one_byte;
    has_res = 1'b0;
    res     = 1'b0;
    if (req == REQ_LOAD) begin
      case (sel)
        SEL_BYTE: begin
          if (idx < 10'd4) byte_words[idx[1:0]] = data;
        end
        SEL_BIGRAM: begin
          bigram_words[idx] = data;
          bigram_set[idx]   = 1'b1;
        end
        SEL_TRIGRAM: begin
          trigram_words[idx] = data;
          trigram_set[idx]   = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      one_byte = (win_count == 0);
      if (win_count >= 1) begin
        pair = {win_newer, qb};
        if (!bigram_words[pair[15:6]][pair[5:0]]) all_hit = 1'b0;
      end
      if (win_count >= 2) begin
        h = avalanche({8'h00, win_older, win_newer, qb});
        if (!trigram_words[h[15:6]][h[5:0]] || !trigram_words[h[31:22]][h[21:16]])
          all_hit = 1'b0;
      end
      win_older = win_newer;
      win_newer = qb;
      if (win_count < 2) win_count++;
      if (last) begin
        has_res   = 1'b1;
        res       = one_byte ? byte_words[qb[7:6]][qb[5:0]] : all_hit;
        win_older = '0;
        win_newer = '0;
        win_count = 0;
        all_hit   = 1'b1;
      end
    end
  endtask

  task automatic drive_beat(input logic req, input logic [1:0] sel, input logic [9:0] idx,
                            input logic [63:0] data, input logic [7:0] qb, input logic last,
                            input bit typed, input bit typed_hit);
    bit has_res;
    bit res;
    @(negedge clk);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {6'b0, qb, data, idx};
    in_tuser  = {sel, req};
    in_tlast  = last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_beat(req, sel, idx, data, qb, last, has_res, res);
    if (req == REQ_LOAD) n_loads++;
    else n_bytes++;
    if (has_res) presence_q = {presence_q, (typed ? typed_hit : res)};
  endtask

  // Writes the bigram and trigram words that the next query byte reads, where they
  // have never been written.
  task automatic fill_gaps(input logic [7:0] qb);
    logic [9:0]  bw;
    logic [31:0] h;
    if (win_count >= 1) begin
      bw = {win_newer, qb[7:6]};
      if (!bigram_set[bw])
        drive_beat(REQ_LOAD, SEL_BIGRAM, bw, dense_word(), 8'h00, 1'b0, 0, 0);
    end
    if (win_count >= 2) begin
      h = avalanche({8'h00, win_older, win_newer, qb});
      if (!trigram_set[h[15:6]])
        drive_beat(REQ_LOAD, SEL_TRIGRAM, h[15:6], dense_word(), 8'h00, 1'b0, 0, 0);
      if (!trigram_set[h[31:22]])
        drive_beat(REQ_LOAD, SEL_TRIGRAM, h[31:22], dense_word(), 8'h00, 1'b0, 0, 0);
    end
  endtask

  task automatic send_query(input int len);
    logic [1:0] sel;
    logic [9:0] idx;
    logic [7:0] qb;
    for (int i = 0; i < len; i++) begin
      // A bitmap word rewritten part-way through the query.
      if (i > 0 && $urandom_range(99) < 8) begin
        sel = 2'($urandom_range(2));
        idx = (sel == SEL_BYTE) ? 10'($urandom_range(3)) : 10'($urandom_range(1023));
        drive_beat(REQ_LOAD, sel, idx, dense_word(), 8'($urandom()), 1'($urandom()), 0, 0);
      end
      qb = 8'($urandom_range(255));
      fill_gaps(qb);
      drive_beat(REQ_QUERY, 2'($urandom()), 10'($urandom()), rand_word(),
                 qb, (i == len - 1), 0, 0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_ask != hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = hold_ask;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (out_tdata[0]) n_present++;
      if (presence_q.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, got maybe_present %0d",
                 $time, out_tdata[0]);
        errors++;
      end else begin
        want = presence_q.pop_front();
        if (out_tdata[0] !== want) begin
          $display("%0t: maybe_present mismatch, expected %0d, got %0d",
                   $time, want, out_tdata[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("%0t: timed out with %0d results outstanding", $time, presence_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int items;
    int base;
    int len;
    int stage;
    logic [1:0] sel;
    logic [9:0] idx;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The byte map is written up front; every other word is written before a query
    // byte first reads it.
    for (int w = 0; w < 4; w++)
      drive_beat(REQ_LOAD, SEL_BYTE, 10'(w), dense_word(), 8'h00, 1'b0, 0, 0);

    snd_idle = 21;
    rcv_idle = 81;
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].req == REQ_QUERY) fill_gaps(DIR_ROWS[r].qb);
      drive_beat(DIR_ROWS[r].req, DIR_ROWS[r].sel, DIR_ROWS[r].idx, DIR_ROWS[r].data,
                 DIR_ROWS[r].qb, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].typed_hit);
    end

    base  = n_loads + n_bytes;
    items = 0;
    stage = 0;
    while (items < RANDOM_ITEMS) begin
      if (stage == 0 && items >= RANDOM_ITEMS / 3) begin
        stage    = 1;
        snd_idle = 81;
        rcv_idle = 21;
      end else if (stage == 1 && items >= 2 * RANDOM_ITEMS / 3) begin
        stage    = 2;
        snd_idle = 0;
        rcv_idle = 0;
        hold_ask++;
      end
      if ($urandom_range(99) < 85) begin
        len = ($urandom_range(99) < 10) ? $urandom_range(12, 5) : $urandom_range(4, 1);
        send_query(len);
      end else begin
        sel = 2'($urandom_range(3));
        idx = (sel == SEL_BYTE && $urandom_range(1)) ? 10'($urandom_range(7))
                                                     : 10'($urandom_range(1023));
        drive_beat(REQ_LOAD, sel, idx, ($urandom_range(3) != 0) ? dense_word() : rand_word(),
                   8'($urandom()), 1'($urandom()), 0, 0);
      end
      items = n_loads + n_bytes - base;
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (presence_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Sent %0d bitmap loads and %0d query bytes; checked %0d results, %0d maybe-present.",
             n_loads, n_bytes, n_results, n_present);
    $display("Idle patterns on both sides and a %0d-cycle receiver hold-off were exercised.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
